// File: sv/c2csc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and control structs of the COO to CSC counting sort.
package c2csc_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ENTRIES_DEF = 65536;

    localparam int KIND_W     = 2;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int SLOT_W     = 16;
    localparam int START_W    = 17;
    localparam int NUMCOL_W   = 11;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 48;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [NUMCOL_W-1:0] NUM_COLUMNS_RST = 11'd1024;
    localparam logic                REG_NUM_COLUMNS = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_COUNT = 2'd0,
        KIND_PLACE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef struct packed {
        logic take;
        logic rd_input;
        logic rd_sweep;
        logic exec;
        logic sweep_zero;
        logic clr_step;
        logic scan_init;
        logic scan_wr;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  need_scan;
        logic  has_result;
        logic  out_busy;
        logic  sweep_last;
    } t_stat;

endpackage

// File: sv/coo_to_csc_counting_sort_core.sv
`timescale 1ns / 1ps
// Flow: an accepted word is registered with its RAM reads in IDLE, then executed in EXEC; place, read and overflowing
// count words load the output register there, which waits while a pending word is not taken; one word at a time.
// The first in-range place word after counting adds the prefix scan over the RAM ports, column by column.
// Clear word: sweep of every counter RAM address; DEPTH = min(MAX_COLUMNS, 1024).
// Reset: synchronous, active low; a clearing pass over all DEPTH counter addresses runs with s_axis_tready low.
module coo_to_csc_counting_sort_core #(
    parameter int MAX_COLUMNS = c2csc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ENTRIES = c2csc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [c2csc_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // row, col
    input  logic [c2csc_pkg::KIND_W-1:0]      s_axis_tuser,  // kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [c2csc_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // slot, row_index, column_start
    output logic [0:0]                        m_axis_tuser,  // overflow
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c2csc_pkg::APB_AW-1:0]      paddr,
    input  logic [c2csc_pkg::APB_DW-1:0]      pwdata,
    output logic [c2csc_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    import c2csc_pkg::*;

    t_cmd                cmd;
    t_stat               stat;
    logic                cfg_sel;
    logic [NUMCOL_W-1:0] cfg_rdata;
    logic [SLOT_W-1:0]   slot;
    logic [ROW_W-1:0]    row_index;
    logic [START_W-1:0]  column_start;
    logic                overflow;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_AW-1:2] == REG_NUM_COLUMNS);
    assign prdata  = APB_DW'(cfg_rdata);

    c2csc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    c2csc_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (t_kind'(s_axis_tuser)),
        .i_row          (s_axis_tdata[ROW_W-1:0]),
        .i_col          (s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
        .i_m_ready      (m_axis_tready),
        .o_m_valid      (m_axis_tvalid),
        .o_slot         (slot),
        .o_row_index    (row_index),
        .o_column_start (column_start),
        .o_overflow     (overflow),
        .i_cfg_we       (psel && penable && pwrite && pready && cfg_sel),
        .i_cfg_sel      (cfg_sel),
        .i_cfg_wdata    (pwdata[NUMCOL_W-1:0]),
        .o_cfg_rdata    (cfg_rdata)
    );

    assign m_axis_tdata = M_TDATA_W'({column_start, row_index, slot});
    assign m_axis_tuser = overflow;

endmodule

// File: sv/c2csc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module c2csc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/c2csc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: item handshake, clear sweep, prefix scan and item execution.
module c2csc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  c2csc_pkg::t_stat i_stat,
    output logic             o_ready,
    output c2csc_pkg::t_cmd  o_cmd
);

    import c2csc_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_EXEC    = 6'b000100,
        S_SCAN_RD = 6'b001000,
        S_SCAN_WR = 6'b010000,
        S_FETCH   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.rd_input = 1'b1;
                if (i_valid) begin
                    cmd.take = 1'b1;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.kind == KIND_CLEAR) begin
                    cmd.exec       = 1'b1;
                    cmd.sweep_zero = 1'b1;
                    n_state        = S_CLEAR;
                end else if (i_stat.need_scan) begin
                    cmd.scan_init  = 1'b1;
                    cmd.sweep_zero = 1'b1;
                    n_state        = S_SCAN_RD;
                end else if (!(i_stat.has_result && i_stat.out_busy)) begin
                    cmd.exec = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                cmd.rd_sweep = 1'b1;
                n_state      = S_SCAN_WR;
            end
            S_SCAN_WR: begin
                cmd.scan_wr = 1'b1;
                n_state     = i_stat.sweep_last ? S_FETCH : S_SCAN_RD;
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = cmd;

    a_take_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take |=> (r_state == S_EXEC))
        else $error("accepted word did not move to execute");

endmodule

// File: sv/c2csc_dp.sv
`timescale 1ns / 1ps
// Datapath: config register, counter and start memories, scan and output register.
module c2csc_dp #(
    parameter int MAX_COLUMNS = c2csc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ENTRIES = c2csc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  c2csc_pkg::t_cmd                 i_cmd,
    output c2csc_pkg::t_stat                o_stat,
    input  c2csc_pkg::t_kind                i_kind,
    input  logic [c2csc_pkg::ROW_W-1:0]     i_row,
    input  logic [c2csc_pkg::COL_W-1:0]     i_col,
    input  logic                            i_m_ready,
    output logic                            o_m_valid,
    output logic [c2csc_pkg::SLOT_W-1:0]    o_slot,
    output logic [c2csc_pkg::ROW_W-1:0]     o_row_index,
    output logic [c2csc_pkg::START_W-1:0]   o_column_start,
    output logic                            o_overflow,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_sel,
    input  logic [c2csc_pkg::NUMCOL_W-1:0]  i_cfg_wdata,
    output logic [c2csc_pkg::NUMCOL_W-1:0]  o_cfg_rdata
);

    import c2csc_pkg::*;

    localparam int DEPTH = (MAX_COLUMNS < (1 << COL_W)) ? MAX_COLUMNS : (1 << COL_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 2);
    localparam logic [NUMCOL_W-1:0] DEPTH_N = NUMCOL_W'(DEPTH);
    localparam logic [AW-1:0]       LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0]       ME_C    = CW'(MAX_ENTRIES);

    // control state
    logic [NUMCOL_W-1:0] r_num_cols;
    logic [CW-1:0]       r_total, n_total;
    logic                r_scan_done, n_scan_done;
    logic [AW-1:0]       r_sweep, n_sweep;
    logic [CW-1:0]       r_running, n_running;
    logic                r_out_valid, n_out_valid;

    // payload
    t_kind               r_kind;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic [SLOT_W-1:0]   r_slot;
    logic [ROW_W-1:0]    r_row_out;
    logic [START_W-1:0]  r_start;
    logic                r_ovf;

    logic [NUMCOL_W-1:0] n_cols;
    logic                col_ok, has_next, cnt_ok, place_ok, sweep_in_use, sweep_last;
    logic                out_busy, has_result, load_out;
    logic [CW-1:0]       limit, start_val;

    logic [AW-1:0]       cnt_raddr, st_raddr, cnt_waddr;
    logic [CW-1:0]       cnt_rdata, st_rdata, cnt_wdata, st_wdata;
    logic                cnt_we;

    // clamp to 1..DEPTH; columns past DEPTH cannot be addressed and behave alike
    always_comb begin
        if (r_num_cols == '0) begin
            n_cols = NUMCOL_W'(1);
        end else if (r_num_cols > DEPTH_N) begin
            n_cols = DEPTH_N;
        end else begin
            n_cols = r_num_cols;
        end
    end

    assign col_ok       = NUMCOL_W'(r_col) < n_cols;
    assign has_next     = (NUMCOL_W'(r_col) + NUMCOL_W'(1)) < n_cols;
    assign sweep_in_use = NUMCOL_W'(r_sweep) < n_cols;
    assign sweep_last   = (r_sweep == LAST_A);

    assign cnt_ok    = col_ok && !r_scan_done && (r_total < ME_C);
    assign limit     = has_next ? (st_rdata - CW'(1)) : r_total;
    assign place_ok  = col_ok && (cnt_rdata < limit) && (cnt_rdata < ME_C);
    assign start_val = col_ok ? st_rdata : (r_total + CW'(1));

    assign has_result = (r_kind == KIND_COUNT) ? !cnt_ok : (r_kind != KIND_CLEAR);
    assign out_busy   = r_out_valid && !i_m_ready;
    assign load_out   = i_cmd.exec && has_result;

    always_comb begin
        if (i_cmd.rd_input) begin
            cnt_raddr = i_col[AW-1:0];
            st_raddr  = (i_kind == KIND_READ) ? i_col[AW-1:0] : AW'(i_col + COL_W'(1));
        end else if (i_cmd.rd_sweep) begin
            cnt_raddr = r_sweep;
            st_raddr  = r_sweep;
        end else begin
            cnt_raddr = r_col[AW-1:0];
            st_raddr  = (r_kind == KIND_READ) ? r_col[AW-1:0] : AW'(r_col + COL_W'(1));
        end
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_col[AW-1:0];
        cnt_wdata = cnt_rdata + CW'(1);
        if (i_cmd.clr_step) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_sweep;
            cnt_wdata = '0;
        end else if (i_cmd.scan_wr) begin
            cnt_we    = sweep_in_use;
            cnt_waddr = r_sweep;
            cnt_wdata = r_running - CW'(1);
        end else if (i_cmd.exec) begin
            cnt_we = ((r_kind == KIND_COUNT) && cnt_ok) || ((r_kind == KIND_PLACE) && place_ok);
        end
    end

    assign st_wdata = sweep_in_use ? r_running : (r_total + CW'(1));

    c2csc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    c2csc_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.scan_wr),
        .i_waddr (r_sweep),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    always_comb begin
        n_total     = r_total;
        n_scan_done = r_scan_done;
        n_sweep     = r_sweep;
        n_running   = r_running;
        n_out_valid = r_out_valid && !i_m_ready;
        if (i_cmd.exec && (r_kind == KIND_CLEAR)) begin
            n_total     = '0;
            n_scan_done = 1'b0;
        end
        if (i_cmd.exec && (r_kind == KIND_COUNT) && cnt_ok) begin
            n_total = r_total + CW'(1);
        end
        if (i_cmd.sweep_zero) begin
            n_sweep = '0;
        end else if (i_cmd.clr_step || i_cmd.scan_wr) begin
            n_sweep = sweep_last ? '0 : r_sweep + AW'(1);
        end
        if (i_cmd.scan_init) begin
            n_running = CW'(1);
        end else if (i_cmd.scan_wr && sweep_in_use) begin
            n_running = r_running + cnt_rdata;
        end
        if (i_cmd.scan_wr && sweep_last) begin
            n_scan_done = 1'b1;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols  <= NUM_COLUMNS_RST;
            r_total     <= '0;
            r_scan_done <= 1'b0;
            r_sweep     <= '0;
            r_running   <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_cols <= i_cfg_wdata;
            end
            r_total     <= n_total;
            r_scan_done <= n_scan_done;
            r_sweep     <= n_sweep;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind <= i_kind;
            r_row  <= i_row;
            r_col  <= i_col;
        end
        if (load_out) begin
            r_slot    <= ((r_kind == KIND_PLACE) && place_ok) ? SLOT_W'(cnt_rdata) : '0;
            r_row_out <= (r_kind == KIND_PLACE) ? r_row : '0;
            r_start   <= (r_kind == KIND_READ) ? START_W'(start_val) : '0;
            r_ovf     <= (r_kind == KIND_COUNT) || ((r_kind == KIND_PLACE) && !place_ok);
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.need_scan  = (r_kind == KIND_PLACE) && col_ok && !r_scan_done;
    assign o_stat.has_result = has_result;
    assign o_stat.out_busy   = out_busy;
    assign o_stat.sweep_last = sweep_last;

    assign o_m_valid      = r_out_valid;
    assign o_slot         = r_slot;
    assign o_row_index    = r_row_out;
    assign o_column_start = r_start;
    assign o_overflow     = r_ovf;
    assign o_cfg_rdata    = i_cfg_sel ? r_num_cols : '0;

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= ME_C)
        else $error("entry total beyond capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !out_busy)
        else $error("result word loaded over a pending word");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_scan_done) |-> $past(i_cmd.scan_wr && sweep_last))
        else $error("scan marked done before last column");

endmodule
